FILE: hw/rtl/stid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stid_pkg: shared definitions for the sorted table
// Table depth, derived widths, command and status codes, and the control
// group that the top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package stid_pkg;

  localparam int DEPTH         = 16;
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int IDX_W         = $clog2(DEPTH);
  localparam int VALUE_W       = 32;
  localparam int ENTRY_COUNT_W = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  // Control broadcast to all cells for one cycle.
  typedef struct packed {
    logic                      ins;   // place value, shift the tail right
    logic                      del;   // drop the matching entry, shift left
    logic                      rot;   // rotate occupied entries by one
    logic signed [VALUE_W-1:0] value; // operand of insert and delete
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/stid_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stid_cell: one slot of the sorted table
// Holds one entry, compares it with the broadcast operand and takes its own
// value, the operand or a neighbor's value on each cycle.
// ----------------------------------------------------------------------------
module stid_cell (
  input  logic                               clk,
  input  stid_pkg::cell_ctrl_t               ctrl,
  input  logic [stid_pkg::IDX_W-1:0]         index,
  input  logic [stid_pkg::CNT_W-1:0]         count,
  input  logic signed [stid_pkg::VALUE_W-1:0] left_val,
  input  logic signed [stid_pkg::VALUE_W-1:0] right_val,
  input  logic signed [stid_pkg::VALUE_W-1:0] head_val,
  input  logic                               lt_left,
  output logic                               lt,
  output logic                               hit,
  output logic signed [stid_pkg::VALUE_W-1:0] val
);
  import stid_pkg::*;

  logic                      occupied;
  logic                      at_pos;
  logic                      is_tail;
  logic signed [VALUE_W-1:0] val_next;

  assign occupied = CNT_W'(index) < count;
  assign is_tail  = (CNT_W'(index) + CNT_W'(1)) == count;
  // Since the table is sorted, the first slot not below the operand is both
  // the insert position and the only place a first equal entry can sit.
  assign lt       = occupied && (val < ctrl.value);
  assign at_pos   = !lt && lt_left;
  assign hit      = at_pos && occupied && (val == ctrl.value);

  always_comb begin
    val_next = val;
    priority if (ctrl.ins) begin
      if (!lt) begin
        val_next = at_pos ? ctrl.value : left_val;
      end
    end else if (ctrl.del) begin
      if (!lt) begin
        val_next = right_val;
      end
    end else if (ctrl.rot) begin
      val_next = is_tail ? head_val : right_val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

FILE: hw/rtl/sorted_table_insert_delete_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_insert_delete_top: sorted table with insert, delete and dump
// Keeps up to DEPTH signed values in ascending order in a chain of
// compare-and-shift cells and streams them out on request.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake           Payload                                  
//   command   start / busy        cmd, value                               
//   result    strobe (no stall)   status, entry_value, entry_count, last   
//
// Insert, delete and the unused command code are each taken at once and
// may follow one another on every cycle; insert and delete give their single
// result beat on the cycle after the command is taken, and the unused code
// gives no beat at all.
// A dump of n stored entries holds busy high while the chain rotates
// once through its occupied cells, giving one beat per cycle from
// the head cell; a dump of an empty table gives one beat and no busy.
// Reset clears the fill count, the controller state and the result strobe;
// the cells themselves are not cleared, since only occupied slots are read.
// The receiver cannot stall, so every beat is shown for exactly one cycle.
module sorted_table_insert_delete_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          cmd,
  input  logic signed [stid_pkg::VALUE_W-1:0] value,
  output logic                                strobe,
  output logic [1:0]                          status,
  output logic signed [stid_pkg::VALUE_W-1:0] entry_value,
  output logic [stid_pkg::ENTRY_COUNT_W-1:0]  entry_count,
  output logic                                last
);
  import stid_pkg::*;

  state_t                    state, state_next;
  logic [CNT_W-1:0]          count, count_next;
  logic [CNT_W-1:0]          dump_idx, dump_idx_next;
  logic                      strobe_next;
  status_t                   status_next;
  logic signed [VALUE_W-1:0] entry_value_next;
  logic [CNT_W-1:0]          entry_count_next;
  logic                      last_next;

  cell_ctrl_t                ctrl;
  logic signed [VALUE_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]          cell_lt;
  logic [DEPTH-1:0]          cell_hit;
  logic                      found;
  logic                      dump_last;

  // The chain: each cell sees its left and right neighbors, the compare
  // result of its left neighbor and the head cell for the dump wrap.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    stid_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .index     (IDX_W'(i)),
      .count     (count),
      .left_val  ((i == 0) ? cell_val[0] : cell_val[(i == 0) ? 0 : i - 1]),
      .right_val (cell_val[(i == DEPTH - 1) ? i : i + 1]),
      .head_val  (cell_val[0]),
      .lt_left   ((i == 0) ? 1'b1 : cell_lt[(i == 0) ? 0 : i - 1]),
      .lt        (cell_lt[i]),
      .hit       (cell_hit[i]),
      .val       (cell_val[i])
    );
  end

  // At most one cell matches, so a plain OR tells whether the value exists.
  assign found     = |cell_hit;
  assign dump_last = (dump_idx + CNT_W'(1)) == count;
  assign busy      = (state == S_DUMP);

  always_comb begin
    state_next       = state;
    count_next       = count;
    dump_idx_next    = dump_idx;
    strobe_next      = 1'b0;
    status_next      = ST_OK;
    entry_value_next = '0;
    last_next        = 1'b0;
    ctrl.ins         = 1'b0;
    ctrl.del         = 1'b0;
    ctrl.rot         = 1'b0;
    ctrl.value       = value;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd)
            CMD_INSERT: begin
              strobe_next = 1'b1;
              last_next   = 1'b1;
              if (count == CNT_W'(DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                ctrl.ins   = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            CMD_DELETE: begin
              strobe_next = 1'b1;
              last_next   = 1'b1;
              priority if (count == '0) begin
                status_next = ST_EMPTY;
              end else if (!found) begin
                status_next = ST_NOTFOUND;
              end else begin
                ctrl.del   = 1'b1;
                count_next = count - CNT_W'(1);
              end
            end
            CMD_DUMP: begin
              if (count == '0) begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                status_next = ST_EMPTY;
              end else begin
                state_next    = S_DUMP;
                dump_idx_next = '0;
              end
            end
            default: begin
              // Unused code: taken and dropped without a result.
            end
          endcase
        end
      end
      S_DUMP: begin
        // The head cell holds the next entry; rotating brings the table
        // back to its original order after exactly count steps.
        strobe_next      = 1'b1;
        entry_value_next = cell_val[0];
        last_next        = dump_last;
        ctrl.rot         = 1'b1;
        dump_idx_next    = dump_idx + CNT_W'(1);
        if (dump_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    entry_count_next = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    dump_idx    <= dump_idx_next;
    status      <= status_next;
    entry_value <= entry_value_next;
    entry_count <= ENTRY_COUNT_W'(entry_count_next);
    last        <= last_next;
  end

endmodule

FILE: hw/rtl/stid_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stid_checker: port-level checks for the sorted table
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
module stid_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic [1:0]                          cmd,
  input logic signed [stid_pkg::VALUE_W-1:0] value,
  input logic                                strobe,
  input logic [1:0]                          status,
  input logic signed [stid_pkg::VALUE_W-1:0] entry_value,
  input logic [stid_pkg::ENTRY_COUNT_W-1:0]  entry_count,
  input logic                                last
);
  import stid_pkg::*;

  // A dump stream has no gaps: a beat that is not the last is followed by one.
  a_stream_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("dump stream broke before its last beat");

  // Every cycle spent busy produces a dump beat on the next cycle.
  a_busy_gives_beat: assert property (@(posedge clk) disable iff (rst)
    busy |=> strobe)
    else $error("busy cycle without a following beat");

  // Insert and delete answer with one final beat on the next cycle.
  a_single_answer: assert property (@(posedge clk) disable iff (rst)
    !rst && start && !busy && (cmd == CMD_INSERT || cmd == CMD_DELETE)
    |=> strobe && last)
    else $error("insert or delete without its answer beat");

  // Error answers carry no entry and always close the item.
  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    strobe && status != ST_OK |-> last && entry_value == '0)
    else $error("error beat with data or without last");

  // A beat that is not the last belongs to a dump: busy is high or was just high.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy || $past(busy))
    else $error("partial dump beat outside a dump");

endmodule

bind sorted_table_insert_delete_top stid_checker u_stid_checker (.*);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted table with insert, delete and dump
// Drives commands over start / busy, keeps a shadow copy of the sorted
// table to predict every result beat, and checks each strobed beat field
// by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;
  import stid_pkg::*;

  // Command code 3 is not decoded by the block; it must be swallowed
  // without a beat and without touching the table.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // The slowest correct run lies far below this limit.
  localparam int CYCLE_LIMIT = 200000;

  // Number of mismatches that still print a line.
  localparam int MAX_PRINTED = 40;

  // One expected result beat, as the block should show it on the strobe.
  typedef struct {
    status_t                   status;
    logic signed [VALUE_W-1:0] val;
    logic [ENTRY_COUNT_W-1:0]  count;
    logic                      last;
  } beat_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic [1:0]                cmd = CMD_INSERT;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      busy;
  logic                      strobe;
  logic [1:0]                status;
  logic signed [VALUE_W-1:0] entry_value;
  logic [ENTRY_COUNT_W-1:0]  entry_count;
  logic                      last;

  // Shadow of the table contents, always kept sorted, and its fill level.
  logic signed [VALUE_W-1:0] sorted_vals [DEPTH];
  int unsigned               stored = 0;

  // Beats predicted but not yet seen, oldest first.
  beat_t pending_beats[$];

  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  // Coverage tallies for the closing summary.
  int n_items = 0;
  int n_beats = 0;
  int n_full = 0;
  int n_empty = 0;
  int n_notfound = 0;
  int n_dumps = 0;
  int peak_fill = 0;

  sorted_table_insert_delete_top uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .value      (value),
    .strobe     (strobe),
    .status     (status),
    .entry_value(entry_value),
    .entry_count(entry_count),
    .last       (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost beat ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d beats still pending.", cycles,
               pending_beats.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  function automatic void queue_beat(input status_t st, input logic signed [VALUE_W-1:0] v,
                                     input logic lst);
    beat_t b;
    b.status = st;
    b.val    = v;
    b.count  = stored[ENTRY_COUNT_W-1:0];
    b.last   = lst;
    pending_beats.push_back(b);
    case (st)
      ST_FULL:     n_full++;
      ST_EMPTY:    n_empty++;
      ST_NOTFOUND: n_notfound++;
      default: ;
    endcase
  endfunction

  // Applies one accepted command to the shadow table and queues the beats it
  // must produce. Inserts go in front of equal values; deletes remove the
  // first equal value. Ordering is signed.
  function automatic void update_table(input logic [1:0] c,
                                       input logic signed [VALUE_W-1:0] v);
    int pos;
    int i;
    case (c)
      CMD_INSERT: begin
        if (stored == DEPTH) begin
          queue_beat(ST_FULL, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < stored && sorted_vals[pos] < v) pos++;
          for (i = stored; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
          sorted_vals[pos] = v;
          stored++;
          if (stored > peak_fill) peak_fill = stored;
          queue_beat(ST_OK, '0, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (stored == 0) begin
          queue_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < stored && sorted_vals[pos] != v) pos++;
          if (pos == stored) begin
            queue_beat(ST_NOTFOUND, '0, 1'b1);
          end else begin
            for (i = pos; i + 1 < stored; i++) sorted_vals[i] = sorted_vals[i+1];
            stored--;
            queue_beat(ST_OK, '0, 1'b1);
          end
        end
      end
      CMD_DUMP: begin
        n_dumps++;
        if (stored == 0) begin
          queue_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < stored; i++) queue_beat(ST_OK, sorted_vals[i], i + 1 == stored);
        end
      end
      default: ;
    endcase
  endfunction

  // Sends one command. Before it, the sender may sit idle for a random run of
  // cycles with junk on cmd and value. The command is taken at the first
  // rising edge with start high and busy low; start is left high on return
  // so that a back-to-back command keeps it high without a glitch.
  task automatic send_cmd(input logic [1:0] c, input logic signed [VALUE_W-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      cmd   <= 2'($urandom_range(3));
      value <= $urandom;
    end
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    update_table(c, v);
    if (c != CMD_UNUSED) n_items++;
  endtask

  // Holds the sender off until every predicted beat has been seen.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
  endtask

  // Random operand: a mix of full-range values, a tight cluster around zero
  // (to breed duplicates) and values at or near both extremes.
  function automatic logic signed [VALUE_W-1:0] rand_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $signed($urandom_range(8)) - 4;
      2: begin
        case ($urandom_range(3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: v = $urandom_range(1) ? 32'sh7FFF_FFF0 + $urandom_range(15)
                                     : 32'sh8000_0000 + $urandom_range(15);
    endcase
    return v;
  endfunction

  // Delete operand: mostly a value that is stored, so deletes hit.
  function automatic logic signed [VALUE_W-1:0] delete_value();
    if (stored != 0 && $urandom_range(99) < 70) return sorted_vals[$urandom_range(stored - 1)];
    return rand_value();
  endfunction

  // Empty-table cases, signed extremes, duplicates, a miss, removal of the
  // head, the tail and the sole entry, and the unused command code.
  task automatic test_directed_edges();
    send_cmd(CMD_DUMP, '0);
    send_cmd(CMD_DELETE, 32'sd5);
    send_cmd(CMD_INSERT, 32'sh7FFF_FFFF);
    send_cmd(CMD_INSERT, 32'sh8000_0000);
    send_cmd(CMD_INSERT, 32'sd0);
    send_cmd(CMD_INSERT, -32'sd1);
    send_cmd(CMD_INSERT, 32'sd0);
    send_cmd(CMD_DUMP, '0);
    send_cmd(CMD_DELETE, 32'sd12345);
    send_cmd(CMD_UNUSED, 32'sh5A5A_A5A5);
    send_cmd(CMD_DELETE, 32'sh7FFF_FFFF);
    send_cmd(CMD_DELETE, 32'sh8000_0000);
    send_cmd(CMD_DUMP, '0);
    send_cmd(CMD_DELETE, 32'sd0);
    send_cmd(CMD_DELETE, 32'sd0);
    send_cmd(CMD_DELETE, -32'sd1);
    send_cmd(CMD_DELETE, -32'sd1);
    send_cmd(CMD_DUMP, '0);
  endtask

  // Fills the table to the brim, bounces an insert off it, dumps all of it,
  // then pauses until it is quiet, empties it again and tries a delete and a dump on the empty table.
  task automatic test_full_table();
    while (stored < DEPTH) send_cmd(CMD_INSERT, rand_value());
    send_cmd(CMD_INSERT, 32'sh7FFF_FFFF);
    send_cmd(CMD_DUMP, '0);
    wait_drained();
    send_cmd(CMD_DELETE, 32'sh1234_5678);
    while (stored > 0) send_cmd(CMD_DELETE, sorted_vals[$urandom_range(stored - 1)]);
    send_cmd(CMD_DELETE, rand_value());
    send_cmd(CMD_DUMP, '0);
  endtask

  // Random traffic. The insert/delete mix drifts toward growth until the
  // table is full and toward shrinkage until it is empty, so the fill level
  // wanders up and down. The unused command code is sprinkled in and not
  // counted toward the item total.
  task automatic test_random_traffic(input int n, input int pct);
    int sent;
    int r;
    bit growing;
    sent = 0;
    growing = 1'b1;
    idle_pct = pct;
    while (sent < n) begin
      if (stored == DEPTH) growing = 1'b0;
      if (stored == 0) growing = 1'b1;
      r = $urandom_range(99);
      if (r < 4) begin
        send_cmd(CMD_UNUSED, rand_value());
      end else begin
        if (r < 14) send_cmd(CMD_DUMP, rand_value());
        else if ($urandom_range(99) < (growing ? 75 : 25)) send_cmd(CMD_INSERT, rand_value());
        else send_cmd(CMD_DELETE, delete_value());
        sent++;
      end
    end
    idle_pct = 0;
  endtask

  // Result monitor: every strobed beat must match the oldest prediction.
  always @(posedge clk) begin : check_beats
    beat_t want;
    if (!rst && strobe) begin
      n_beats++;
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("beat with nothing pending: status=%0d value=%0d count=%0d",
                                  status, entry_value, entry_count));
      end else begin
        want = pending_beats.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (entry_value !== want.val)
          report_mismatch($sformatf("entry_value %0d, want %0d", entry_value, want.val));
        if (entry_count !== want.count)
          report_mismatch($sformatf("entry_count %0d, want %0d", entry_count, want.count));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", last, want.last));
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_full_table();

    // The receiver cannot stall, so only the sender side takes gaps. The
    // phases run with no gaps, with the sender idle half the time, and with
    // the sender idle about a quarter of the time.
    test_random_traffic(15, 0);
    test_random_traffic(15, 50);
    test_random_traffic(15, 24);

    @(negedge clk);
    start <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    // A stray beat would show within a dump's length of quiet cycles.
    repeat (DEPTH + 4) @(posedge clk);

    $display("Ran %0d commands (%0d dumps), checked %0d beats; peak fill %0d of %0d.",
             n_items, n_dumps, n_beats, peak_fill, DEPTH);
    $display("Hit full %0d, empty %0d, not found %0d times; %0d mismatches.",
             n_full, n_empty, n_notfound, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
